// ===== hdl/etcc_pkg.sv =====
// ============================================================================
// etcc_pkg
// Shared types and constants for the extended timer with compare channels.
// ============================================================================
package etcc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_ARM_ONCE   = 2'd1,
        CMD_ARM_PERIOD = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DSEL_F    = 2'd0,
        DSEL_D    = 2'd1,
        DSEL_PROD = 2'd2
    } dsel_t;

    localparam logic       CFG_PRESCALE = 1'b0;
    localparam logic       CFG_BUS_CLK  = 1'b1;
    localparam logic [31:0] BUS_CLK_RESET = 32'd8000000;
    localparam logic [2:0] DIV_STEPS     = 3'd6;
    localparam logic [2:0] US_SHIFT      = 3'd3;
    localparam logic [63:0] RECIP_10     = 64'hCCCCCCCD;
    localparam int          RECIP_10_SH  = 35;
    localparam logic [63:0] RECIP_1000   = 64'h10624DD3;
    localparam int          RECIP_1000_SH = 38;
    localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;

    typedef struct packed {
        logic  capture;
        logic  f_step;
        logic  div_init;
        logic  div_step;
        logic  d_step;
        logic  mul;
        logic  p_step;
        logic  apply;
        logic  load_out;
        dsel_t div_sel;
    } ctl_t;

    typedef struct packed {
        logic f_zero;
        logic f_can_div;
        logic div_last;
        logic d_can_div;
        logic steps_left;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/extended_timer_with_compare_channels.sv =====
// ============================================================================
// extended_timer_with_compare_channels
// Prescaled timer with overflow extension and one-shot/periodic compares.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) takes one beat per command: tick,
//   arm one-shot, arm periodic or read time, with delay_us for arm beats.
//   Every beat gives exactly one result beat on out_valid/out_stall with
//   the fire flags and the current time in cycles, microseconds, millis.
//   Tick and read beats pass through an apply state and an emit state,
//   which loads the output register. Arm beats first add the delay
//   conversion: 6 decade steps shared between frequency, delay and product,
//   a bit-serial restoring divide of all-ones by the frequency for the delay
//   bound and one multiply, using the shared divide-by-ten unit.
//   One beat is in work at a time; a new beat is taken while a finished
//   result still waits in the output register. A stalled output holds its
//   beat and the next result waits until the register frees.
//   Config writes (cfg_valid/cfg_ready, always ready) set prescale and the
//   bus clock. They must be made only while idle; the block does not
//   enforce this. Reset clears the timer and both channels, prescale to 0,
//   bus clock to 8 MHz.
// ============================================================================
module extended_timer_with_compare_channels #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] delay_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        once_fired,
    output logic        period_fired,
    output logic [31:0] cycles_now,
    output logic [31:0] micros_now,
    output logic [22:0] millis_now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import etcc_pkg::*;

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    etcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .ctl      (ctl),
        .sts      (sts)
    );

    etcc_dpath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .delay_us     (delay_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .once_fired   (once_fired),
        .period_fired (period_fired),
        .cycles_now   (cycles_now),
        .micros_now   (micros_now),
        .millis_now   (millis_now)
    );

endmodule

// ===== hdl/etcc_ctrl.sv =====
// ============================================================================
// etcc_ctrl
// Sequencer for command capture, delay conversion, state update and output.
// ============================================================================
module etcc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      cmd,
    output etcc_pkg::ctl_t  ctl,
    input  etcc_pkg::sts_t  sts
);
    import etcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FTEN,
        S_BOUND,
        S_DTEN,
        S_MUL,
        S_PTEN,
        S_APPLY,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        ctl.div_sel = DSEL_PROD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    if (cmd_t'(cmd) == CMD_ARM_ONCE || cmd_t'(cmd) == CMD_ARM_PERIOD)
                        state_next = S_FTEN;
                    else
                        state_next = S_APPLY;
                end
            end
            S_FTEN:
            begin
                ctl.div_sel = DSEL_F;
                if (sts.f_zero)
                    state_next = S_APPLY;
                else if (sts.f_can_div)
                    ctl.f_step = 1'b1;
                else
                begin
                    ctl.div_init = 1'b1;
                    state_next   = S_BOUND;
                end
            end
            S_BOUND:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_DTEN;
            end
            S_DTEN:
            begin
                ctl.div_sel = DSEL_D;
                if (sts.d_can_div)
                    ctl.d_step = 1'b1;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_PTEN;
            end
            S_PTEN:
            begin
                ctl.div_sel = DSEL_PROD;
                if (sts.steps_left)
                    ctl.p_step = 1'b1;
                else
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                ctl.apply  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_arm_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall &&
         (cmd_t'(cmd) == CMD_ARM_ONCE || cmd_t'(cmd) == CMD_ARM_PERIOD))
        |=> state_reg == S_FTEN)
        else $error("arm beat did not start conversion");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second beat taken while busy");
    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> sts.out_free)
        else $error("output loaded over a pending beat");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BOUND && sts.div_last) |=> state_reg == S_DTEN)
        else $error("divider end not followed");
`endif

endmodule

// ===== hdl/etcc_dpath.sv =====
// ============================================================================
// etcc_dpath
// Config registers, delay conversion units, timer state and output register.
// ============================================================================
module etcc_dpath #(
    parameter int COUNTER_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  etcc_pkg::ctl_t  ctl,
    output etcc_pkg::sts_t  sts,
    input  logic            cfg_valid,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic [1:0]      cmd,
    input  logic [31:0]     delay_us,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            once_fired,
    output logic            period_fired,
    output logic [31:0]     cycles_now,
    output logic [31:0]     micros_now,
    output logic [22:0]     millis_now
);
    import etcc_pkg::*;

    localparam int CB     = COUNTER_BITS;
    localparam int PASS_W = (CB >= 32) ? 1 : 32 - CB;

    logic [2:0]  prescale_reg;
    logic [31:0] bus_clk_reg;

    cmd_t        cmd_reg;
    logic [31:0] f_reg;
    logic [31:0] dly_reg;
    logic [31:0] prod_reg;
    logic [2:0]  steps_reg;
    logic [31:0] drem_reg;
    logic [31:0] dquo_reg;
    logic [4:0]  dcnt_reg;

    logic [CB-1:0]     tick_reg;
    logic [31:0]       ovf_reg;
    logic              once_armed_reg;
    logic [CB-1:0]     once_cmp_reg;
    logic [PASS_W-1:0] once_pass_reg;
    logic              per_armed_reg;
    logic [CB-1:0]     per_cmp_reg;
    logic [PASS_W-1:0] per_pass_reg;
    logic [PASS_W-1:0] per_reload_reg;
    logic [CB-1:0]     per_rem_reg;
    logic              once_f_reg;
    logic              per_f_reg;

    logic              out_valid_reg;
    logic              out_once_reg;
    logic              out_per_reg;
    logic [31:0]       out_cyc_reg;
    logic [31:0]       out_us_reg;
    logic [22:0]       out_ms_reg;

    // divide by ten
    logic [31:0] d10_in;
    logic [63:0] d10_prod;
    logic [31:0] d10_q;
    logic [31:0] d10_r;

    always_comb
    begin
        case (ctl.div_sel)
            DSEL_F:    d10_in = f_reg;
            DSEL_D:    d10_in = dly_reg;
            DSEL_PROD: d10_in = prod_reg;
            default:   d10_in = prod_reg;
        endcase
    end

    assign d10_prod = {32'd0, d10_in} * RECIP_10;
    assign d10_q    = 32'(d10_prod >> RECIP_10_SH);
    assign d10_r    = d10_in - ((d10_q << 3) + (d10_q << 1));

    // restoring divide of all-ones by f
    logic [32:0] div_try;
    logic        div_ge;
    assign div_try = {drem_reg, 1'b1};
    assign div_ge  = (div_try >= {1'b0, f_reg});

    // tick split
    logic [CB+31:0]    t_ext;
    logic [PASS_W-1:0] t_pass;
    logic [CB-1:0]     t_rem;
    assign t_ext  = {{CB{1'b0}}, prod_reg};
    assign t_pass = PASS_W'(t_ext >> CB);
    assign t_rem  = (t_ext[CB-1:0] == '0 && t_pass == '0) ? CB'(1) : t_ext[CB-1:0];

    logic [CB-1:0] tick_inc;
    assign tick_inc = tick_reg + CB'(1);

    // time outputs
    logic [CB+31:0] cyc_wide;
    logic [31:0]    cyc;
    logic [31:0]    us;
    logic [63:0]    ms_prod;
    assign cyc_wide = {ovf_reg, tick_reg};
    assign cyc      = cyc_wide[31:0];
    assign us       = (prescale_reg >= US_SHIFT) ? (cyc << (prescale_reg - US_SHIFT))
                                                 : (cyc >> (US_SHIFT - prescale_reg));
    assign ms_prod  = {32'd0, us} * RECIP_1000;

    assign sts.f_zero     = (f_reg == '0);
    assign sts.f_can_div  = (steps_reg != '0) && (d10_r == '0);
    assign sts.div_last   = (dcnt_reg == 5'd31);
    assign sts.d_can_div  = (steps_reg != '0) && (dly_reg > dquo_reg);
    assign sts.steps_left = (steps_reg != '0);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            bus_clk_reg  <= BUS_CLK_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PRESCALE)
                prescale_reg <= cfg_data[2:0];
            else
                bus_clk_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd_t'(cmd);
            f_reg     <= bus_clk_reg >> prescale_reg;
            dly_reg   <= delay_us;
            prod_reg  <= '0;
            steps_reg <= DIV_STEPS;
        end
        if (ctl.f_step)
        begin
            f_reg     <= d10_q;
            steps_reg <= steps_reg - 3'd1;
        end
        if (ctl.div_init)
        begin
            drem_reg <= '0;
            dquo_reg <= '0;
            dcnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            drem_reg <= div_ge ? 32'(div_try - {1'b0, f_reg}) : div_try[31:0];
            dquo_reg <= {dquo_reg[30:0], div_ge};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (ctl.d_step)
        begin
            dly_reg   <= d10_q;
            steps_reg <= steps_reg - 3'd1;
        end
        if (ctl.mul)
            prod_reg <= f_reg * dly_reg;
        if (ctl.p_step)
        begin
            prod_reg  <= d10_q;
            steps_reg <= steps_reg - 3'd1;
        end
        if (ctl.load_out)
        begin
            out_once_reg <= once_f_reg;
            out_per_reg  <= per_f_reg;
            out_cyc_reg  <= cyc;
            out_us_reg   <= us;
            out_ms_reg   <= ms_prod[RECIP_1000_SH+22:RECIP_1000_SH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            ovf_reg        <= '0;
            once_armed_reg <= 1'b0;
            once_cmp_reg   <= '0;
            once_pass_reg  <= '0;
            per_armed_reg  <= 1'b0;
            per_cmp_reg    <= '0;
            per_pass_reg   <= '0;
            per_reload_reg <= '0;
            per_rem_reg    <= '0;
            once_f_reg     <= 1'b0;
            per_f_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.apply)
            begin
                once_f_reg <= 1'b0;
                per_f_reg  <= 1'b0;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        tick_reg <= tick_inc;
                        if (tick_inc == '0)
                            ovf_reg <= ovf_reg + 32'd1;
                        if (once_armed_reg && tick_inc == once_cmp_reg)
                        begin
                            if (once_pass_reg != '0)
                                once_pass_reg <= once_pass_reg - PASS_W'(1);
                            else
                            begin
                                once_armed_reg <= 1'b0;
                                once_f_reg     <= 1'b1;
                            end
                        end
                        if (per_armed_reg && tick_inc == per_cmp_reg)
                        begin
                            if (per_pass_reg != '0)
                                per_pass_reg <= per_pass_reg - PASS_W'(1);
                            else
                            begin
                                per_pass_reg <= per_reload_reg;
                                per_cmp_reg  <= per_cmp_reg + per_rem_reg;
                                per_f_reg    <= 1'b1;
                            end
                        end
                    end
                    CMD_ARM_ONCE:
                    begin
                        once_pass_reg  <= t_pass;
                        once_cmp_reg   <= tick_reg + t_rem;
                        once_armed_reg <= 1'b1;
                    end
                    CMD_ARM_PERIOD:
                    begin
                        per_pass_reg   <= t_pass;
                        per_reload_reg <= t_pass;
                        per_rem_reg    <= t_rem;
                        per_cmp_reg    <= tick_reg + t_rem;
                        per_armed_reg  <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign once_fired   = out_once_reg;
    assign period_fired = out_per_reg;
    assign cycles_now   = out_cyc_reg;
    assign micros_now   = out_us_reg;
    assign millis_now   = out_ms_reg;

endmodule
